// ===== hw/rtl/irt_pkg.sv =====
`default_nettype none

package irt_pkg;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_START  = 4'd1,
    ST_RSTART = 4'd2,
    ST_SPACE  = 4'd3,
    ST_BYTE1  = 4'd4,
    ST_BYTE2  = 4'd5,
    ST_BYTE3  = 4'd6,
    ST_BYTE4  = 4'd7,
    ST_GAP    = 4'd8
  } state_t;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_STANDARD = 2'd1,
    ACT_CUSTOM   = 2'd2,
    ACT_STOP     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_START_MARK  = 3'd0,
    REG_START_SPACE = 3'd1,
    REG_ONE_SPACE   = 3'd2,
    REG_ZERO_SPACE  = 3'd3,
    REG_REPEAT_GAP  = 3'd4
  } cfg_reg_t;

  localparam int unsigned CfgIndexWidth = 3;

  localparam logic [3:0] BIT_TOP  = 4'd7;
  localparam logic [3:0] BIT_DONE = 4'd15;

  localparam logic [7:0] START_MARK_RESET  = 8'd80;
  localparam logic [7:0] START_SPACE_RESET = 8'd80;
  localparam logic [7:0] ONE_SPACE_RESET   = 8'd30;
  localparam logic [7:0] ZERO_SPACE_RESET  = 8'd10;
  localparam logic [7:0] REPEAT_GAP_RESET  = 8'd200;

  typedef struct packed {
    logic [7:0] start_mark_ticks;
    logic [7:0] start_space_ticks;
    logic [7:0] one_space_ticks;
    logic [7:0] zero_space_ticks;
    logic [7:0] repeat_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] command_check;
    logic       repeat_enable;
  } request_t;

  typedef struct packed {
    logic       ir_level;
    logic       busy_res;
    logic [3:0] state_code;
    logic       start_accepted;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ir_remote_frame_transmitter.sv =====
// Pulse-distance IR frame transmitter, one request per timer tick.
// Input channel (in_valid/in_ready): action selects tick, standard start,
// custom start or stop; address, command, command_check and repeat_enable
// go with a start. Each accepted request yields exactly one result on the
// output channel (out_valid/out_ready): ir_level gates the carrier,
// busy_res and state_code show the frame state, start_accepted flags a
// start that was taken (starts are only taken in idle or repeat start).
// A request is first captured in the input register; the frame state and
// the result register then update together once the output can take a
// result. Throughput: one request per cycle while out_ready is high; the
// state update between the two registers is combinational.
// When out_ready is low the result register holds, the input register
// fills and in_ready drops until the result is taken.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
// and should be written only while no request is in flight.
// Reset: state idle, FSM IR level high, timing registers at their defaults.
`default_nettype none

module ir_remote_frame_transmitter (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [irt_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  wire logic [7:0]                         cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         action,
  input  wire logic [7:0]                         address,
  input  wire logic [7:0]                         command,
  input  wire logic [7:0]                         command_check,
  input  wire logic                               repeat_enable,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    ir_level,
  output logic                                    busy_res,
  output logic [3:0]                              state_code,
  output logic                                    start_accepted
);
  import irt_pkg::*;

  cfg_t     cfg;
  request_t req;
  logic     req_valid;
  logic     advance;
  result_t  result_next;
  result_t  result;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req.action        <= action;
      req.address       <= address;
      req.command       <= command;
      req.command_check <= command_check;
      req.repeat_enable <= repeat_enable;
    end
  end

  irt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  irt_frame_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .req         (req),
    .cfg         (cfg),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign ir_level       = result.ir_level;
  assign busy_res       = result.busy_res;
  assign state_code     = result.state_code;
  assign start_accepted = result.start_accepted;

endmodule

`default_nettype wire

// ===== hw/rtl/irt_cfg_regs.sv =====
`default_nettype none

module irt_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [irt_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  wire logic [7:0]                          cfg_data,
  output irt_pkg::cfg_t                            cfg
);
  import irt_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_mark_ticks  <= START_MARK_RESET;
      cfg.start_space_ticks <= START_SPACE_RESET;
      cfg.one_space_ticks   <= ONE_SPACE_RESET;
      cfg.zero_space_ticks  <= ZERO_SPACE_RESET;
      cfg.repeat_gap_ticks  <= REPEAT_GAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_MARK:  cfg.start_mark_ticks  <= cfg_data;
        REG_START_SPACE: cfg.start_space_ticks <= cfg_data;
        REG_ONE_SPACE:   cfg.one_space_ticks   <= cfg_data;
        REG_ZERO_SPACE:  cfg.zero_space_ticks  <= cfg_data;
        REG_REPEAT_GAP:  cfg.repeat_gap_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/irt_frame_fsm.sv =====
`default_nettype none

module irt_frame_fsm (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire irt_pkg::request_t req,
  input  wire irt_pkg::cfg_t     cfg,
  output irt_pkg::result_t       result_next
);
  import irt_pkg::*;

  state_t     frame_state, frame_state_next;
  logic       repeat_flag, repeat_flag_next;
  logic [7:0] tick_count, tick_count_next;
  logic       bit_phase, bit_phase_next;
  logic [3:0] bit_index, bit_index_next;
  logic       level_reg, level_reg_next;
  logic [7:0] frame_bytes [4];
  logic       load_bytes;
  logic       accepted;

  logic [3:0] state_bits;
  logic [7:0] cur_byte;
  logic       cur_bit;
  logic [7:0] bit_len;
  logic [7:0] bit_count;
  logic [7:0] count_inc;

  assign state_bits = frame_state;
  assign cur_byte   = frame_bytes[state_bits[1:0]];
  assign cur_bit    = cur_byte[bit_index[2:0]];
  assign bit_len    = cur_bit ? cfg.one_space_ticks : cfg.zero_space_ticks;
  assign count_inc  = tick_count + 8'd1;
  // a fresh bit space restarts the counter at zero
  assign bit_count  = bit_phase ? count_inc : 8'd0;

  always_comb begin
    frame_state_next = frame_state;
    repeat_flag_next = repeat_flag;
    tick_count_next  = tick_count;
    bit_phase_next   = bit_phase;
    bit_index_next   = bit_index;
    level_reg_next   = level_reg;
    load_bytes       = 1'b0;
    accepted         = 1'b0;

    unique case (action_t'(req.action))
      ACT_TICK: begin
        unique case (frame_state)
          ST_START, ST_RSTART: begin
            if (tick_count >= cfg.start_mark_ticks) begin
              level_reg_next   = 1'b0;
              frame_state_next = ST_SPACE;
              tick_count_next  = 8'd1;
            end else begin
              level_reg_next  = 1'b1;
              tick_count_next = count_inc;
            end
          end
          ST_SPACE: begin
            if (tick_count >= cfg.start_space_ticks) begin
              level_reg_next   = 1'b1;
              frame_state_next = ST_BYTE1;
              tick_count_next  = 8'd1;
            end else begin
              tick_count_next = count_inc;
            end
          end
          ST_BYTE1, ST_BYTE2, ST_BYTE3, ST_BYTE4: begin
            level_reg_next  = bit_phase ? level_reg : 1'b0;
            bit_phase_next  = 1'b1;
            tick_count_next = bit_count;
            if (bit_count == bit_len) begin
              level_reg_next  = 1'b1;
              tick_count_next = 8'd0;
              bit_phase_next  = 1'b0;
              bit_index_next  = bit_index - 4'd1;
              if (bit_index == 4'd0) begin
                // last bit of the byte went out
                bit_index_next = BIT_TOP;
                if (frame_state == ST_BYTE4) begin
                  frame_state_next = repeat_flag ? ST_GAP : ST_IDLE;
                end else begin
                  frame_state_next = state_t'(state_bits + 4'd1);
                end
              end
            end
          end
          ST_GAP: begin
            level_reg_next  = 1'b0;
            tick_count_next = count_inc;
            if (count_inc > cfg.repeat_gap_ticks) begin
              frame_state_next = ST_RSTART;
              tick_count_next  = 8'd0;
            end
          end
          default: begin
            level_reg_next   = 1'b0;
            frame_state_next = ST_IDLE;
            repeat_flag_next = 1'b0;
            tick_count_next  = 8'd0;
            bit_phase_next   = 1'b0;
            bit_index_next   = BIT_TOP;
          end
        endcase
      end
      ACT_STOP: begin
        level_reg_next   = 1'b0;
        frame_state_next = ST_IDLE;
        repeat_flag_next = 1'b0;
        tick_count_next  = 8'd0;
        bit_phase_next   = 1'b0;
        bit_index_next   = BIT_TOP;
      end
      default: begin
        if (frame_state == ST_IDLE || frame_state == ST_RSTART) begin
          load_bytes       = 1'b1;
          accepted         = 1'b1;
          tick_count_next  = 8'd0;
          bit_index_next   = BIT_TOP;
          repeat_flag_next = req.repeat_enable;
          frame_state_next = ST_START;
        end
      end
    endcase
  end

  always_comb begin
    result_next.ir_level       = level_reg_next;
    result_next.busy_res       = (frame_state_next != ST_IDLE);
    result_next.state_code     = frame_state_next;
    result_next.start_accepted = accepted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_state <= ST_IDLE;
      repeat_flag <= 1'b0;
      tick_count  <= 8'd0;
      bit_phase   <= 1'b0;
      bit_index   <= BIT_TOP;
      level_reg   <= 1'b1;
    end else if (step) begin
      frame_state <= frame_state_next;
      repeat_flag <= repeat_flag_next;
      tick_count  <= tick_count_next;
      bit_phase   <= bit_phase_next;
      bit_index   <= bit_index_next;
      level_reg   <= level_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && load_bytes) begin
      frame_bytes[0] <= req.address;
      frame_bytes[1] <= req.address;
      frame_bytes[2] <= req.command;
      frame_bytes[3] <= (action_t'(req.action) == ACT_STANDARD) ? ~req.command
                                                                 : req.command_check;
    end
  end

endmodule

`default_nettype wire
